// ===== hw/rtl/aasc_pkg.sv =====
// Shared types and constants for the activity and step counter.
// Holds the sequencer state type, word kinds, register indexes and the
// pedometer control struct. No dependencies.
package aasc_pkg;

  // Field widths
  localparam int AXIS_W   = 16;
  localparam int WORD_W   = 32;
  localparam int SUM_W    = 64;
  localparam int MAG_W    = 17;
  localparam int AMP_W    = 15;
  localparam int STEP_W   = 16;
  localparam int SHIFT_W  = 5;
  localparam int CFG_W    = 16;
  localparam int N_AXES   = 3;
  localparam int AX_IDX_W = 2;

  // Digit-serial squaring: digit size and digits per operand
  localparam int DIGIT_W  = 4;
  localparam int N_DIGITS = WORD_W / DIGIT_W;
  localparam int DCNT_W   = $clog2(N_DIGITS + 1);

  // Square root starts from the top even bit
  localparam logic [WORD_W-1:0] SQRT_TOP_BIT = 32'h4000_0000;
  // Pedometer amplitude clamp
  localparam logic [AMP_W-1:0]  PED_CLAMP    = 15'h7FFF;

  // Register reset values
  localparam logic [SHIFT_W-1:0] RST_DC_SHIFT  = 5'd4;
  localparam logic [AMP_W-1:0]   RST_MIN_LEVEL = 15'd100;
  localparam logic [STEP_W-1:0]  RST_MIN_INTV  = 16'd10;
  localparam logic [STEP_W-1:0]  RST_MAX_INTV  = 16'd100;

  // Input word kinds
  typedef enum logic [1:0] {
    KIND_SAMPLE     = 2'd0,
    KIND_EPOCH      = 2'd1,
    KIND_PED_INIT   = 2'd2,
    KIND_READ_CLEAR = 2'd3
  } kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DC_SHIFT  = 2'd0,
    CFG_MIN_LEVEL = 2'd1,
    CFG_MIN_INTV  = 2'd2,
    CFG_MAX_INTV  = 2'd3
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DC,
    ST_HP,
    ST_MUL,
    ST_ROOT,
    ST_PEAK,
    ST_DETECT,
    ST_EXEC,
    ST_FINISH
  } state_t;

  // Pedometer commands from the sequencer
  typedef struct packed {
    logic upd_peak;
    logic upd_detect;
    logic init;
    logic clear;
  } ped_ctrl_t;

endpackage

// ===== hw/rtl/aasc_sqmac.sv =====
// Digit-serial square-and-accumulate unit, modulo 2^32.
// Squares one operand a digit per cycle and adds it into a running sum.
// Depends on aasc_pkg.
module aasc_sqmac import aasc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              load,
  input  logic [WORD_W-1:0] operand,
  output logic              busy,
  output logic [WORD_W-1:0] acc
);

  logic [WORD_W-1:0] mcand_r, mcand_nxt;
  logic [WORD_W-1:0] mplier_r, mplier_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [WORD_W-1:0] partial;

  // One digit of the multiplier times the shifted multiplicand
  assign partial = WORD_W'(mcand_r * mplier_r[DIGIT_W-1:0]);

  // Load, advance one digit, or hold
  always_comb begin
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    if (clr) begin
      acc_nxt = '0;
    end
    if (load) begin
      mcand_nxt  = operand;
      mplier_nxt = operand;
      cnt_nxt    = DCNT_W'(N_DIGITS);
    end else if (cnt_r != '0) begin
      acc_nxt    = acc_r + partial;
      mcand_nxt  = mcand_r << DIGIT_W;
      mplier_nxt = mplier_r >> DIGIT_W;
      cnt_nxt    = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      acc_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      acc_r <= acc_nxt;
    end
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign busy = (cnt_r != '0);
  assign acc  = acc_r;

endmodule

// ===== hw/rtl/aasc_sqrt.sv =====
// Bit-serial rounded integer square root of a 32-bit word.
// Resolves one root bit per cycle, then applies rounding. Depends on aasc_pkg.
module aasc_sqrt import aasc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] radicand,
  output logic              busy,
  output logic [MAG_W-1:0]  root
);

  logic [WORD_W-1:0] op_r, op_nxt;
  logic [WORD_W-1:0] res_r, res_nxt;
  logic [WORD_W-1:0] one_r, one_nxt;
  logic              run_r, run_nxt;
  logic [WORD_W-1:0] trial;

  assign trial = res_r + one_r;

  // Iterate while the probe bit is set, then round and stop
  always_comb begin
    op_nxt  = op_r;
    res_nxt = res_r;
    one_nxt = one_r;
    run_nxt = run_r;
    if (start) begin
      op_nxt  = radicand;
      res_nxt = '0;
      one_nxt = SQRT_TOP_BIT;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (one_r != '0) begin
        if (op_r >= trial) begin
          op_nxt  = op_r - trial;
          res_nxt = (res_r + (one_r << 1)) >> 1;
        end else begin
          res_nxt = res_r >> 1;
        end
        one_nxt = one_r >> 2;
      end else begin
        if (op_r > res_r) begin
          res_nxt = res_r + 1'b1;
        end
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
    end
    op_r  <= op_nxt;
    res_r <= res_nxt;
    one_r <= one_nxt;
  end

  assign busy = run_r;
  assign root = res_r[MAG_W-1:0];

endmodule

// ===== hw/rtl/aasc_ped.sv =====
// Peak-to-peak pedometer: max/min trackers, phase detector and step counts.
// Updates peaks on the peak command and runs detection on the detect command. Depends on aasc_pkg.
module aasc_ped import aasc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ped_ctrl_t               ctrl,
  input  logic [AMP_W-1:0]        amp,
  input  logic signed [AXIS_W-1:0] init_level,
  input  logic [AMP_W-1:0]        min_level,
  input  logic [STEP_W-1:0]       min_intv,
  input  logic [STEP_W-1:0]       max_intv,
  output logic [STEP_W-1:0]       step_count,
  output logic [STEP_W-1:0]       total_steps,
  output logic [AMP_W-1:0]        activity_level
);

  logic signed [AXIS_W-1:0] max_r, max_nxt;
  logic signed [AXIS_W-1:0] min_r, min_nxt;
  logic signed [AXIS_W-1:0] level_r, level_nxt;
  logic                     phase_r, phase_nxt;
  logic [STEP_W-1:0]        intv_r, intv_nxt;
  logic [STEP_W-1:0]        total_r, total_nxt;
  logic [STEP_W-1:0]        since_r, since_nxt;

  logic signed [AXIS_W:0]   level_p1;
  logic signed [AXIS_W:0]   decay17;
  logic signed [AXIS_W-1:0] decay;
  logic signed [AXIS_W-1:0] amp_s;
  logic signed [AXIS_W-1:0] max_dec;
  logic signed [AXIS_W-1:0] min_dec;
  logic signed [AXIS_W-1:0] lvl;
  logic signed [AXIS_W-1:0] quarter;
  logic signed [AXIS_W-1:0] tlow;
  logic signed [AXIS_W-1:0] thigh;
  logic                     active;
  logic [STEP_W-1:0]        intv_tmp;
  logic [STEP_W-1:0]        intv_inc;

  // Decay of the peak trackers and the range thresholds
  assign amp_s    = $signed({1'b0, amp});
  assign level_p1 = $signed({level_r[AXIS_W-1], level_r}) + 17'sd1;
  assign decay17  = level_p1 >>> 3;
  assign decay    = decay17[AXIS_W-1:0];
  assign max_dec  = max_r - decay;
  assign min_dec  = min_r + decay;
  assign lvl      = max_r - min_r;
  assign quarter  = lvl >>> 2;
  assign tlow     = min_r + quarter;
  assign thigh    = max_r - quarter;
  assign active   = $signed({lvl[AXIS_W-1], lvl}) > $signed({2'b00, min_level});

  always_comb begin
    max_nxt   = max_r;
    min_nxt   = min_r;
    level_nxt = level_r;
    phase_nxt = phase_r;
    intv_nxt  = intv_r;
    total_nxt = total_r;
    since_nxt = since_r;
    intv_tmp  = intv_r;
    intv_inc  = '0;
    priority if (ctrl.init) begin
      // Restart the pedometer at the given level
      max_nxt   = init_level;
      min_nxt   = init_level;
      level_nxt = '0;
      phase_nxt = 1'b0;
      intv_nxt  = '0;
      total_nxt = '0;
      since_nxt = '0;
    end else if (ctrl.clear) begin
      since_nxt = '0;
    end else if (ctrl.upd_peak) begin
      // Decay toward each other, then fast attack on the new amplitude
      max_nxt = (max_dec <= amp_s) ? amp_s : max_dec;
      min_nxt = (min_dec >= amp_s) ? amp_s : min_dec;
    end else if (ctrl.upd_detect) begin
      level_nxt = lvl;
      if (active) begin
        if (amp_s < tlow) begin
          phase_nxt = 1'b1;
        end else if (phase_r && (amp_s > thigh) && (intv_r > min_intv)) begin
          intv_tmp  = '0;
          phase_nxt = 1'b0;
          total_nxt = total_r + 1'b1;
          since_nxt = since_r + 1'b1;
        end
        // Advance the interval and drop the phase on timeout
        intv_inc = intv_tmp + 1'b1;
        if (intv_inc > max_intv) begin
          intv_nxt  = min_intv;
          phase_nxt = 1'b0;
        end else begin
          intv_nxt = intv_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= '0;
      min_r   <= '0;
      level_r <= '0;
      phase_r <= 1'b0;
      intv_r  <= '0;
      total_r <= '0;
      since_r <= '0;
    end else begin
      max_r   <= max_nxt;
      min_r   <= min_nxt;
      level_r <= level_nxt;
      phase_r <= phase_nxt;
      intv_r  <= intv_nxt;
      total_r <= total_nxt;
      since_r <= since_nxt;
    end
  end

  assign step_count     = since_r;
  assign total_steps    = total_r;
  assign activity_level = level_r[AMP_W-1:0];

endmodule

// ===== hw/rtl/accel_activity_and_step_counter_unit.sv =====
// Accelerometer activity and step counter, top level.
// Sequencer, DC trackers, epoch accumulator and output register.
// Depends on aasc_pkg, aasc_sqmac, aasc_sqrt and aasc_ped.
//
// Input channel (in_*): one word per item; in_tuser carries the kind
// (sample, start epoch, pedometer init, read and clear steps), in_tdata the
// three axis samples and the pedometer init level. Output channel (out_*):
// one word per item with magnitude, epoch counters, step counts and level.
// Configuration channel (cfg_*): index and data, always ready.
// A sample word passes per axis through the DC tracker, the high-pass value
// and the digit-serial square (8 digits of 4 bits), then through the
// bit-serial square root (16 root bits and rounding), the pedometer peak and
// detect updates and the output register load. Other kinds pass through the
// execute state to the output register load.
// One word is in flight at a time; the next is accepted once the result has
// moved into the output register, so a result waiting on out_tready does not
// block intake until the following result is ready.
// Reset restores default registers and clears trackers, epoch counters and
// pedometer state. When the receiver stalls, the finished result holds in
// the sequencer until the output register frees.
module accel_activity_and_step_counter_unit import aasc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [63:0]   in_tdata,   // accel_x, accel_y, accel_z, initial_level
  input  logic [1:0]    in_tuser,   // kind
  output logic          out_tvalid,
  input  logic          out_tready,
  // magnitude, samples_in_epoch, epoch_sum, step_count, total_steps,
  // activity_level
  output logic [159:0]  out_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  // Configuration registers
  logic [SHIFT_W-1:0] shift_r;
  logic [AMP_W-1:0]   min_level_r;
  logic [STEP_W-1:0]  min_intv_r;
  logic [STEP_W-1:0]  max_intv_r;

  // Captured item
  kind_t                    kind_r;
  logic signed [AXIS_W-1:0] axis_r [N_AXES];
  logic signed [AXIS_W-1:0] init_r;
  logic [AX_IDX_W-1:0]      ax_r;

  // Tracker and epoch state
  logic [WORD_W-1:0] dc_r [N_AXES];
  logic [WORD_W-1:0] cnt_r;
  logic [SUM_W-1:0]  sum_r;
  logic [MAG_W-1:0]  mag_r;

  // Output register
  logic         out_valid_r;
  logic [159:0] out_data_r;

  // Sequencer controls
  logic      accept;
  logic      out_free;
  logic      mac_clr, mac_load, mac_busy;
  logic      root_start, root_busy;
  logic      dc_we, epoch_init, accum, out_load, ax_adv;
  ped_ctrl_t ped_ctrl;

  // Datapath wires
  logic [WORD_W-1:0]  x_ext;
  logic [WORD_W-1:0]  dc_cur;
  logic [WORD_W-1:0]  dc_shr;
  logic [WORD_W-1:0]  dc_new;
  logic [WORD_W-1:0]  hp;
  logic [WORD_W-1:0]  mac_acc;
  logic [MAG_W-1:0]   root;
  logic [AMP_W-1:0]   amp;
  logic [STEP_W-1:0]  step_count;
  logic [STEP_W-1:0]  total_steps;
  logic [AMP_W-1:0]   activity_level;

  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // DC tracker and high-pass value of the current axis
  assign x_ext  = WORD_W'(axis_r[ax_r]);
  assign dc_cur = dc_r[ax_r];
  assign dc_shr = WORD_W'($signed(dc_cur) >>> shift_r);
  assign dc_new = dc_cur - dc_shr + x_ext;
  assign hp     = x_ext - dc_shr;

  // Clamp the magnitude for the pedometer
  assign amp = (mag_r > MAG_W'(PED_CLAMP)) ? PED_CLAMP : mag_r[AMP_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (kind_t'(in_tuser) == KIND_SAMPLE) ? ST_DC : ST_EXEC;
        end
      end
      ST_DC:     state_nxt = ST_HP;
      ST_HP:     state_nxt = ST_MUL;
      ST_MUL: begin
        if (!mac_busy) begin
          state_nxt = (ax_r == AX_IDX_W'(N_AXES - 1)) ? ST_ROOT : ST_DC;
        end
      end
      ST_ROOT: begin
        if (!root_busy && !root_start) begin
          state_nxt = ST_PEAK;
        end
      end
      ST_PEAK:   state_nxt = ST_DETECT;
      ST_DETECT: state_nxt = ST_FINISH;
      ST_EXEC:   state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  logic root_pending_r;

  always_comb begin
    in_tready  = 1'b0;
    mac_clr    = 1'b0;
    mac_load   = 1'b0;
    root_start = 1'b0;
    dc_we      = 1'b0;
    epoch_init = 1'b0;
    accum      = 1'b0;
    out_load   = 1'b0;
    ax_adv     = 1'b0;
    ped_ctrl   = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        mac_clr   = in_tvalid;
      end
      ST_DC:  dc_we    = 1'b1;
      ST_HP:  mac_load = 1'b1;
      ST_MUL: begin
        if (!mac_busy) begin
          if (ax_r == AX_IDX_W'(N_AXES - 1)) begin
            root_start = 1'b1;
          end else begin
            ax_adv = 1'b1;
          end
        end
      end
      ST_ROOT: begin
        accum = !root_busy && !root_pending_r;
      end
      ST_PEAK:   ped_ctrl.upd_peak   = 1'b1;
      ST_DETECT: ped_ctrl.upd_detect = 1'b1;
      ST_EXEC: begin
        epoch_init    = (kind_r == KIND_EPOCH);
        ped_ctrl.init = (kind_r == KIND_PED_INIT);
      end
      ST_FINISH: begin
        out_load       = out_free;
        ped_ctrl.clear = out_free && (kind_r == KIND_READ_CLEAR);
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Root start lands in the cycle before its busy flag rises
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      root_pending_r <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      root_pending_r <= root_start;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= RST_DC_SHIFT;
      min_level_r <= RST_MIN_LEVEL;
      min_intv_r  <= RST_MIN_INTV;
      max_intv_r  <= RST_MAX_INTV;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DC_SHIFT:  shift_r     <= cfg_data[SHIFT_W-1:0];
        CFG_MIN_LEVEL: min_level_r <= cfg_data[AMP_W-1:0];
        CFG_MIN_INTV:  min_intv_r  <= cfg_data;
        CFG_MAX_INTV:  max_intv_r  <= cfg_data;
        default:       shift_r     <= shift_r;
      endcase
    end
  end

  // Capture the accepted word and step the axis index
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= kind_t'(in_tuser);
      axis_r[0] <= in_tdata[15:0];
      axis_r[1] <= in_tdata[31:16];
      axis_r[2] <= in_tdata[47:32];
      init_r    <= in_tdata[63:48];
      ax_r      <= '0;
    end else if (ax_adv) begin
      ax_r <= ax_r + 1'b1;
    end
  end

  // DC trackers, epoch counters and magnitude
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_AXES; i++) begin
        dc_r[i] <= '0;
      end
      cnt_r <= '0;
      sum_r <= '0;
      mag_r <= '0;
    end else begin
      if (accept) begin
        mag_r <= '0;
      end
      if (dc_we) begin
        dc_r[ax_r] <= dc_new;
      end
      if (epoch_init) begin
        for (int i = 0; i < N_AXES; i++) begin
          dc_r[i] <= WORD_W'(axis_r[i]) << shift_r;
        end
        cnt_r <= '0;
        sum_r <= '0;
      end
      if (accum) begin
        mag_r <= root;
        sum_r <= sum_r + SUM_W'(root);
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_data_r <= {activity_level, total_steps, step_count, sum_r, cnt_r, mag_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  aasc_sqmac u_sqmac (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (mac_clr),
    .load    (mac_load),
    .operand (hp),
    .busy    (mac_busy),
    .acc     (mac_acc)
  );

  aasc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (mac_acc),
    .busy     (root_busy),
    .root     (root)
  );

  aasc_ped u_ped (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ped_ctrl),
    .amp            (amp),
    .init_level     (init_r),
    .min_level      (min_level_r),
    .min_intv       (min_intv_r),
    .max_intv       (max_intv_r),
    .step_count     (step_count),
    .total_steps    (total_steps),
    .activity_level (activity_level)
  );

endmodule
